/* rtl/i2cmbe_pkg.sv */
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Types and constants shared by the I2C master byte engine modules.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned DELAY_W       = 16;

	// Request kinds
	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_STOP  = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	// Bus phases, one-hot
	typedef enum logic [20:0] {
		PH_IDLE     = 21'd1,
		PH_ST_REL   = 21'd1 << 1,
		PH_ST_SDA   = 21'd1 << 2,
		PH_ST_SCL   = 21'd1 << 3,
		PH_SP_SCL_L = 21'd1 << 4,
		PH_SP_SDA_L = 21'd1 << 5,
		PH_SP_SCL_H = 21'd1 << 6,
		PH_SP_SDA_H = 21'd1 << 7,
		PH_WB_SCL_L = 21'd1 << 8,
		PH_WB_SDA   = 21'd1 << 9,
		PH_WB_SCL_H = 21'd1 << 10,
		PH_WA_SCL_L = 21'd1 << 11,
		PH_WA_SDA_H = 21'd1 << 12,
		PH_WA_SCL_H = 21'd1 << 13,
		PH_WA_END   = 21'd1 << 14,
		PH_RB_SCL_L = 21'd1 << 15,
		PH_RB_SCL_H = 21'd1 << 16,
		PH_RA_SCL_L = 21'd1 << 17,
		PH_RA_SDA   = 21'd1 << 18,
		PH_RA_SCL_H = 21'd1 << 19,
		PH_RA_END   = 21'd1 << 20
	} phase_t;

	// One tick of input
	typedef struct packed {
		logic       cmd_valid;
		req_t       req_type;
		logic [7:0] wr_byte;
		logic       send_ack;
		logic       sda_in;
	} tick_t;

	// Bus drives and status after one tick
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       ready_res;
		logic       done_res;
		logic [7:0] rd_byte;
		logic       ack_seen;
		logic       start_error;
	} res_t;

endpackage

/* rtl/i2cmbe_sequencer.sv */
// ----------------------------------------------------------------------------
// i2cmbe_sequencer
// Phase sequencer: advances the bus state by one tick per accepted request
// and reports the drives and status that the tick leaves behind.
// ----------------------------------------------------------------------------
module i2cmbe_sequencer
	import i2cmbe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [DELAY_W-1:0] cfg_wdata,
	input  logic               step,
	input  tick_t              tick,
	output res_t               res
);

	localparam logic [3:0] BYTE_BITS = 4'(BITS_PER_BYTE);

	logic [DELAY_W-1:0] delay_q;
	phase_t             phase_q,  phase_n;
	req_t               cmd_q,    cmd_n;
	logic [3:0]         bit_q,    bit_n;
	logic [7:0]         shift_q,  shift_n;
	logic [DELAY_W-1:0] tick_q,   tick_n;
	logic               scl_q,    scl_n;
	logic               sda_q,    sda_n;
	logic               ackc_q,   ackc_n;
	logic               sack_q,   sack_n;

	logic               enter;
	logic               done;
	logic               err;
	logic [DELAY_W-1:0] lim;
	logic [DELAY_W-1:0] tick_inc;

	// Phase length, zero acts as one
	assign lim      = (delay_q == '0) ? DELAY_W'(1) : delay_q;
	assign tick_inc = tick_q + DELAY_W'(1);

	// Next state for one tick
	always_comb begin
		phase_n = phase_q;
		cmd_n   = cmd_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		tick_n  = tick_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		ackc_n  = ackc_q;
		sack_n  = sack_q;
		enter   = 1'b0;
		done    = 1'b0;
		err     = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (tick.cmd_valid) begin
				cmd_n = tick.req_type;
				bit_n = '0;
				enter = 1'b1;
				case (tick.req_type)
					REQ_START: phase_n = PH_ST_REL;
					REQ_STOP:  phase_n = PH_SP_SCL_L;
					REQ_WRITE: begin
						shift_n = tick.wr_byte;
						sack_n  = 1'b0;
						phase_n = PH_WB_SCL_L;
					end
					default: begin
						shift_n = '0;
						ackc_n  = tick.send_ack;
						sda_n   = 1'b1;
						phase_n = PH_RB_SCL_L;
					end
				endcase
			end
		end else if (tick_inc >= lim) begin
			enter = 1'b1;
			case (phase_q)
				PH_ST_REL: begin
					if (!tick.sda_in) begin
						err   = 1'b1;
						done  = 1'b1;
						enter = 1'b0;
					end else begin
						phase_n = PH_ST_SDA;
					end
				end
				PH_ST_SDA:   phase_n = PH_ST_SCL;
				PH_SP_SCL_L: phase_n = PH_SP_SDA_L;
				PH_SP_SDA_L: phase_n = PH_SP_SCL_H;
				PH_SP_SCL_H: phase_n = PH_SP_SDA_H;
				PH_WB_SCL_L: phase_n = PH_WB_SDA;
				PH_WB_SDA:   phase_n = PH_WB_SCL_H;
				PH_WB_SCL_H: begin
					shift_n = {shift_q[6:0], 1'b0};
					bit_n   = bit_q + 4'd1;
					phase_n = (bit_n >= BYTE_BITS) ? PH_WA_SCL_L : PH_WB_SCL_L;
				end
				PH_WA_SCL_L: phase_n = PH_WA_SDA_H;
				PH_WA_SDA_H: phase_n = PH_WA_SCL_H;
				PH_WA_SCL_H: begin
					sack_n  = ~tick.sda_in;
					phase_n = PH_WA_END;
				end
				PH_RB_SCL_L: phase_n = PH_RB_SCL_H;
				PH_RB_SCL_H: begin
					shift_n = {shift_q[6:0], tick.sda_in};
					bit_n   = bit_q + 4'd1;
					phase_n = (bit_n >= BYTE_BITS) ? PH_RA_SCL_L : PH_RB_SCL_L;
				end
				PH_RA_SCL_L: phase_n = PH_RA_SDA;
				PH_RA_SDA:   phase_n = PH_RA_SCL_H;
				PH_RA_SCL_H: phase_n = PH_RA_END;
				default: begin
					done  = 1'b1;
					enter = 1'b0;
				end
			endcase
			if (done) begin
				phase_n = PH_IDLE;
				tick_n  = '0;
			end
		end else begin
			tick_n = tick_inc;
		end

		// Apply the drives of a newly entered phase
		if (enter) begin
			tick_n = '0;
			case (phase_n)
				PH_ST_REL: begin
					scl_n = 1'b1;
					sda_n = 1'b1;
				end
				PH_ST_SDA, PH_SP_SDA_L:                           sda_n = 1'b0;
				PH_SP_SDA_H, PH_WA_SDA_H:                         sda_n = 1'b1;
				PH_WB_SDA:                                        sda_n = shift_n[7];
				PH_RA_SDA:                                        sda_n = ~ackc_n;
				PH_SP_SCL_H, PH_WB_SCL_H, PH_WA_SCL_H,
				PH_RB_SCL_H, PH_RA_SCL_H:                         scl_n = 1'b1;
				PH_ST_SCL, PH_SP_SCL_L, PH_WB_SCL_L, PH_WA_SCL_L,
				PH_WA_END, PH_RB_SCL_L, PH_RA_SCL_L, PH_RA_END:   scl_n = 1'b0;
				default: ;
			endcase
		end
	end

	// Result of this tick
	always_comb begin
		res.scl_out     = scl_n;
		res.sda_out     = sda_n;
		res.ready_res   = (phase_n == PH_IDLE);
		res.done_res    = done;
		res.rd_byte     = (done && cmd_n == REQ_READ) ? shift_n : 8'd0;
		res.ack_seen    = done && (cmd_n == REQ_WRITE) && sack_n;
		res.start_error = done && (cmd_n == REQ_START) && err;
	end

	// Hold the phase length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_W'(1);
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	// Advance the bus state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= REQ_START;
			bit_q   <= '0;
			shift_q <= '0;
			tick_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ackc_q  <= 1'b0;
			sack_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			cmd_q   <= cmd_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			tick_q  <= tick_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			ackc_q  <= ackc_n;
			sack_q  <= sack_n;
		end
	end

endmodule

/* rtl/i2c_master_byte_engine_unit.sv */
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// I2C master byte engine: start, stop, write byte and read byte on
// open-drain SCL and SDA, one bus tick per input request.
// ----------------------------------------------------------------------------
// Each input request is one bus tick and yields exactly one result: the SCL
// and SDA drives after that tick plus idle, done, read byte, slave ack and
// start error status. One request is taken every clock while the input side
// is ready, i.e. the output register is empty or drained in the same cycle;
// the result appears in it on the clock after acceptance. A command offered
// while a command runs is ignored. The user writes delay_ticks (0 counts as 1)
// via cfg_we/cfg_wdata only while the engine is idle; this is not enforced.
module i2c_master_byte_engine_unit
	import i2cmbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,       // delay_ticks
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,    // wr_byte[7:0], send_ack[8], sda_in[9], zero
	input  logic [2:0]  s_axis_tuser,    // cmd_valid[0], req_type[2:1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata     // scl_out[0], sda_out[1], ready_res[2],
	                                     // done_res[3], rd_byte[11:4],
	                                     // ack_seen[12], start_error[13], zero
);

	tick_t       tick;
	res_t        res;
	logic        step;
	logic        out_valid_q;
	logic [15:0] out_data_q;

	// Unpack the input request
	always_comb begin
		tick.cmd_valid = s_axis_tuser[0];
		tick.req_type  = req_t'(s_axis_tuser[2:1]);
		tick.wr_byte   = s_axis_tdata[7:0];
		tick.send_ack  = s_axis_tdata[8];
		tick.sda_in    = s_axis_tdata[9];
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign step          = s_axis_tvalid && s_axis_tready;

	i2cmbe_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.tick      (tick),
		.res       (res)
	);

	// Track result occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= {2'b00, res.start_error, res.ack_seen, res.rd_byte,
			               res.done_res, res.ready_res, res.sda_out, res.scl_out};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
